[rtl/scroll_address_register_unit_assert.svh]
// ---------------------------------------------------------------------------
// scroll address register unit assertion macros
// shared concurrent assertion forms clocked on i_clk
// ---------------------------------------------------------------------------
`ifndef SCROLL_ADDRESS_REGISTER_UNIT_ASSERT_SVH
`define SCROLL_ADDRESS_REGISTER_UNIT_ASSERT_SVH

// checked only outside reset
`define SAR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked in and out of reset
`define SAR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/sar_pkg.sv]
// ---------------------------------------------------------------------------
// sar_pkg
// types and constants of the scroll and address register unit
// ---------------------------------------------------------------------------
package sar_pkg;

    // action codes of the command word
    typedef enum logic [3:0] {
        ACT_CTRL_WR   = 4'd0,
        ACT_SCROLL_WR = 4'd1,
        ACT_ADDR_WR   = 4'd2,
        ACT_STATUS_RD = 4'd3,
        ACT_DATA      = 4'd4,
        ACT_INC_X     = 4'd5,
        ACT_INC_Y     = 4'd6,
        ACT_COPY_X    = 4'd7,
        ACT_COPY_Y    = 4'd8,
        ACT_NONE      = 4'd9
    } t_action;

    localparam logic [13:0] TILE_BASE  = 14'h2000;
    localparam logic [13:0] ATTR_BASE  = 14'h23C0;
    localparam logic [4:0]  COARSE_MAX = 5'd31;
    localparam logic [4:0]  ROW_LAST   = 5'd29;
    localparam logic [2:0]  FINE_MAX   = 3'd7;
    localparam logic [14:0] STEP_ONE   = 15'd1;
    localparam logic [14:0] STEP_ROW   = 15'd32;

    // architectural register set
    typedef struct packed {
        logic [14:0] cur_addr;
        logic [14:0] tmp_addr;
        logic [2:0]  fine_x;
        logic        second_write;
        logic        step_by_32;
        logic        bg_table_high;
    } t_regs;

    // result word
    typedef struct packed {
        logic [14:0] vram_address;
        logic [13:0] tile_fetch_address;
        logic [13:0] attribute_fetch_address;
        logic [2:0]  attribute_shift;
        logic [12:0] pattern_low_address;
        logic [2:0]  fine_x_scroll;
        logic        write_toggle;
    } t_result;

endpackage

[rtl/sar_if.sv]
// ---------------------------------------------------------------------------
// sar channel interfaces
// command and result channels with valid/ready handshake
// ---------------------------------------------------------------------------

// command channel
interface sar_cmd_if;
    logic        valid;
    logic        ready;
    logic [3:0]  action;
    logic [7:0]  data_byte;
    logic        writes_enabled;
    logic [7:0]  tile_number;

    modport source (output valid, action, data_byte, writes_enabled, tile_number,
                    input ready);
    modport sink   (input valid, action, data_byte, writes_enabled, tile_number,
                    output ready);
endinterface

// result channel
interface sar_res_if;
    logic        valid;
    logic        ready;
    logic [14:0] vram_address;
    logic [13:0] tile_fetch_address;
    logic [13:0] attribute_fetch_address;
    logic [2:0]  attribute_shift;
    logic [12:0] pattern_low_address;
    logic [2:0]  fine_x_scroll;
    logic        write_toggle;

    modport source (output valid, vram_address, tile_fetch_address,
                    attribute_fetch_address, attribute_shift,
                    pattern_low_address, fine_x_scroll, write_toggle,
                    input ready);
    modport sink   (input valid, vram_address, tile_fetch_address,
                    attribute_fetch_address, attribute_shift,
                    pattern_low_address, fine_x_scroll, write_toggle,
                    output ready);
endinterface

[rtl/sar_next.sv]
// ---------------------------------------------------------------------------
// sar_next
// next value of the scroll and address registers for one action
// ---------------------------------------------------------------------------
module sar_next (
    input  sar_pkg::t_regs  i_regs,
    input  logic [3:0]      i_action,
    input  logic [7:0]      i_data_byte,
    input  logic            i_writes_enabled,
    output sar_pkg::t_regs  o_regs
);
    import sar_pkg::*;

    logic [14:0] v;
    logic [14:0] t;
    logic [14:0] v_inc_x;
    logic [14:0] v_inc_y;
    logic [4:0]  coarse_y;
    logic [14:0] t_addr_lo;

    assign v = i_regs.cur_addr;
    assign t = i_regs.tmp_addr;

    // coarse x step with horizontal nametable flip
    always_comb begin
        v_inc_x = v;
        if (v[4:0] == COARSE_MAX) begin
            v_inc_x[4:0] = '0;
            v_inc_x[10]  = ~v[10];
        end else begin
            v_inc_x[4:0] = v[4:0] + 5'd1;
        end
    end

    // fine y / coarse y step, row 29 flips the vertical nametable
    always_comb begin
        v_inc_y  = v;
        coarse_y = v[9:5];
        if (v[14:12] != FINE_MAX) begin
            v_inc_y[14:12] = v[14:12] + 3'd1;
        end else begin
            v_inc_y[14:12] = '0;
            if (coarse_y == ROW_LAST) begin
                v_inc_y[9:5] = '0;
                v_inc_y[11]  = ~v[11];
            end else if (coarse_y == COARSE_MAX) begin
                v_inc_y[9:5] = '0;
            end else begin
                v_inc_y[9:5] = coarse_y + 5'd1;
            end
        end
    end

    // second address byte goes into t and then into v
    assign t_addr_lo = {t[14:8], i_data_byte};

    // action decode
    always_comb begin
        o_regs = i_regs;
        unique case (t_action'(i_action))
            ACT_CTRL_WR: begin
                if (i_writes_enabled) begin
                    o_regs.tmp_addr[11:10] = i_data_byte[1:0];
                    o_regs.step_by_32      = i_data_byte[2];
                    o_regs.bg_table_high   = i_data_byte[4];
                end
            end
            ACT_SCROLL_WR: begin
                if (i_writes_enabled) begin
                    if (!i_regs.second_write) begin
                        o_regs.tmp_addr[4:0] = i_data_byte[7:3];
                        o_regs.fine_x        = i_data_byte[2:0];
                        o_regs.second_write  = 1'b1;
                    end else begin
                        o_regs.tmp_addr[9:5]   = i_data_byte[7:3];
                        o_regs.tmp_addr[14:12] = i_data_byte[2:0];
                        o_regs.second_write    = 1'b0;
                    end
                end
            end
            ACT_ADDR_WR: begin
                if (i_writes_enabled) begin
                    if (!i_regs.second_write) begin
                        o_regs.tmp_addr[13:8] = i_data_byte[5:0];
                        o_regs.tmp_addr[14]   = 1'b0;
                        o_regs.second_write   = 1'b1;
                    end else begin
                        o_regs.tmp_addr     = t_addr_lo;
                        o_regs.cur_addr     = t_addr_lo;
                        o_regs.second_write = 1'b0;
                    end
                end
            end
            ACT_STATUS_RD: begin
                o_regs.second_write = 1'b0;
            end
            ACT_DATA: begin
                o_regs.cur_addr = v + (i_regs.step_by_32 ? STEP_ROW : STEP_ONE);
            end
            ACT_INC_X: begin
                o_regs.cur_addr = v_inc_x;
            end
            ACT_INC_Y: begin
                o_regs.cur_addr = v_inc_y;
            end
            ACT_COPY_X: begin
                o_regs.cur_addr[4:0] = t[4:0];
                o_regs.cur_addr[10]  = t[10];
            end
            ACT_COPY_Y: begin
                o_regs.cur_addr[9:5]   = t[9:5];
                o_regs.cur_addr[11]    = t[11];
                o_regs.cur_addr[14:12] = t[14:12];
            end
            default: begin
                o_regs = i_regs;
            end
        endcase
    end

endmodule

[rtl/sar_fetch.sv]
// ---------------------------------------------------------------------------
// sar_fetch
// background fetch addresses formed from the register set
// ---------------------------------------------------------------------------
module sar_fetch (
    input  sar_pkg::t_regs    i_regs,
    input  logic [7:0]        i_tile_number,
    output sar_pkg::t_result  o_res
);
    import sar_pkg::*;

    logic [14:0] v;

    assign v = i_regs.cur_addr;

    // address formatting
    always_comb begin
        o_res.vram_address            = v;
        o_res.tile_fetch_address      = TILE_BASE | {2'b00, v[11:0]};
        o_res.attribute_fetch_address = ATTR_BASE | {2'b00, v[11:10], 4'b0000,
                                                     v[9:7], v[4:2]};
        o_res.attribute_shift         = {v[6], v[1], 1'b0};
        o_res.pattern_low_address     = {i_regs.bg_table_high, i_tile_number,
                                         1'b0, v[14:12]};
        o_res.fine_x_scroll           = i_regs.fine_x;
        o_res.write_toggle            = i_regs.second_write;
    end

endmodule

[rtl/scroll_address_register_unit.sv]
// ---------------------------------------------------------------------------
// scroll_address_register_unit
// scroll/address register set of a tile video chip with fetch addresses
// ---------------------------------------------------------------------------
//   channel  dir  handshake    word
//   i_cmd    in   valid/ready  action, data_byte, writes_enabled, tile_number
//   o_res    out  valid/ready  v, tile/attr/pattern addresses, fine x, toggle
//
// one command word per cycle while i_cmd.ready is high; its result appears in the cycle
// after acceptance, set by the single result register after the register update logic
// synchronous active-low reset clears the scroll registers and the result valid
// i_cmd.ready drops only while a result is held and o_res.ready is low
// ---------------------------------------------------------------------------
`include "scroll_address_register_unit_assert.svh"

module scroll_address_register_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sar_cmd_if.sink       i_cmd,
    sar_res_if.source     o_res
);
    import sar_pkg::*;

    t_regs   r_regs;
    t_regs   n_regs;
    t_result r_res;
    t_result n_res;
    logic    r_valid;
    logic    cmd_acc;

    // handshake
    assign i_cmd.ready = !r_valid || o_res.ready;
    assign cmd_acc     = i_cmd.valid && i_cmd.ready;

    // register update for the action
    sar_next u_next (
        .i_regs           (r_regs),
        .i_action         (i_cmd.action),
        .i_data_byte      (i_cmd.data_byte),
        .i_writes_enabled (i_cmd.writes_enabled),
        .o_regs           (n_regs)
    );

    // fetch addresses from the updated registers
    sar_fetch u_fetch (
        .i_regs        (n_regs),
        .i_tile_number (i_cmd.tile_number),
        .o_res         (n_res)
    );

    // architectural registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= '0;
        end else if (cmd_acc) begin
            r_regs <= n_regs;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (cmd_acc) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (cmd_acc) begin
            r_res <= n_res;
        end
    end

    // result outputs
    assign o_res.valid                   = r_valid;
    assign o_res.vram_address            = r_res.vram_address;
    assign o_res.tile_fetch_address      = r_res.tile_fetch_address;
    assign o_res.attribute_fetch_address = r_res.attribute_fetch_address;
    assign o_res.attribute_shift         = r_res.attribute_shift;
    assign o_res.pattern_low_address     = r_res.pattern_low_address;
    assign o_res.fine_x_scroll           = r_res.fine_x_scroll;
    assign o_res.write_toggle            = r_res.write_toggle;

    // assertions
    `SAR_ASSERT(a_acc_gives_result, cmd_acc |=> r_valid,
        "accepted word gave no result")
    `SAR_ASSERT(a_status_clears,
        (cmd_acc && i_cmd.action == ACT_STATUS_RD) |=> !r_regs.second_write,
        "status read left toggle set")
    `SAR_ASSERT(a_regs_hold, !cmd_acc |=> $stable(r_regs),
        "registers changed without a word")
    `SAR_ASSERT(a_result_tracks_v,
        r_valid |-> (r_res.vram_address == r_regs.cur_addr),
        "result v differs from register")
    `SAR_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !r_valid,
        "result valid after reset")

endmodule

[verif/scroll_address_register_unit_tb.sv]
// ---------------------------------------------------------------------------
// scroll_address_register_unit_tb
// drives command words into the scroll/address register unit and checks
// every result word against a register-level predictor of v, t, fine x,
// the write toggle and the control bits, under random stalls on both sides
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module scroll_address_register_unit_tb;
    import sar_pkg::*;

    // action codes with no function, treated as no action
    localparam logic [3:0] ACT_UNUSED_LOW = 4'd10;
    localparam logic [3:0] ACT_UNUSED_TOP = 4'd15;

    // mismatch lines printed before going quiet
    localparam int unsigned PRINT_CAP = 40;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sar_cmd_if cmd_ch ();
    sar_res_if res_ch ();

    scroll_address_register_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    // predicted register set
    logic [14:0] v_addr;
    logic [14:0] t_addr;
    logic [2:0]  fine_x;
    logic        toggle;
    logic        step_32;
    logic        bg_high;

    t_result     fetch_words_due[$];
    t_result     seen_word;
    t_result     due_word;
    int unsigned mismatch_count = 0;
    int unsigned action_count   = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // run limit
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input int unsigned got,
                                 input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    // register update for one word, then the fetch view of the new state
    task automatic advance_scroll_regs(input logic [3:0] act, input logic [7:0] data,
                                       input logic wen, input logic [7:0] tile,
                                       output t_result view);
        logic [4:0] row;
        case (act)
            ACT_CTRL_WR: begin
                if (wen) begin
                    t_addr[11:10] = data[1:0];
                    step_32       = data[2];
                    bg_high       = data[4];
                end
            end
            ACT_SCROLL_WR: begin
                if (wen && !toggle) begin
                    t_addr[4:0] = data[7:3];
                    fine_x      = data[2:0];
                    toggle      = 1'b1;
                end else if (wen) begin
                    t_addr[9:5]   = data[7:3];
                    t_addr[14:12] = data[2:0];
                    toggle        = 1'b0;
                end
            end
            ACT_ADDR_WR: begin
                if (wen && !toggle) begin
                    t_addr[13:8] = data[5:0];
                    t_addr[14]   = 1'b0;
                    toggle       = 1'b1;
                end else if (wen) begin
                    t_addr[7:0] = data;
                    v_addr      = t_addr;
                    toggle      = 1'b0;
                end
            end
            ACT_STATUS_RD: toggle = 1'b0;
            ACT_DATA:      v_addr = v_addr + (step_32 ? STEP_ROW : STEP_ONE);
            ACT_INC_X: begin
                if (v_addr[4:0] == COARSE_MAX) begin
                    v_addr[4:0] = '0;
                    v_addr[10]  = ~v_addr[10];
                end else begin
                    v_addr[4:0] = v_addr[4:0] + 5'd1;
                end
            end
            ACT_INC_Y: begin
                if (v_addr[14:12] != FINE_MAX) begin
                    v_addr[14:12] = v_addr[14:12] + 3'd1;
                end else begin
                    v_addr[14:12] = '0;
                    row = v_addr[9:5];
                    // last visible row flips the vertical table, row 31 just wraps
                    if (row == ROW_LAST) begin
                        row        = '0;
                        v_addr[11] = ~v_addr[11];
                    end else if (row == COARSE_MAX) begin
                        row = '0;
                    end else begin
                        row = row + 5'd1;
                    end
                    v_addr[9:5] = row;
                end
            end
            ACT_COPY_X: begin
                v_addr[4:0] = t_addr[4:0];
                v_addr[10]  = t_addr[10];
            end
            ACT_COPY_Y: begin
                v_addr[9:5]   = t_addr[9:5];
                v_addr[11]    = t_addr[11];
                v_addr[14:12] = t_addr[14:12];
            end
            default: ;
        endcase

        view.vram_address            = v_addr;
        view.tile_fetch_address      = TILE_BASE | {2'b00, v_addr[11:0]};
        view.attribute_fetch_address = ATTR_BASE | {2'b00, v_addr[11:10], 4'b0000,
                                                    v_addr[9:7], v_addr[4:2]};
        view.attribute_shift         = {v_addr[6], v_addr[1], 1'b0};
        view.pattern_low_address     = {bg_high, tile, 1'b0, v_addr[14:12]};
        view.fine_x_scroll           = fine_x;
        view.write_toggle            = toggle;
    endtask

    // send one command word and log its expected result on acceptance
    task automatic send_word(input logic [3:0] act, input logic [7:0] data,
                             input logic wen, input logic [7:0] tile);
        t_result view;
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid          <= 1'b1;
        cmd_ch.action         <= act;
        cmd_ch.data_byte      <= data;
        cmd_ch.writes_enabled <= wen;
        cmd_ch.tile_number    <= tile;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        advance_scroll_regs(act, data, wen, tile, view);
        fetch_words_due.push_back(view);
        // ignored words do not count toward the random budget
        if (act <= ACT_COPY_Y && !(act <= ACT_ADDR_WR && !wen))
            action_count++;
    endtask

    // hold off the sender until every result is back
    task automatic wait_results_drained;
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (fetch_words_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic logic mostly_enabled();
        return ($urandom_range(9) != 0);
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            seen_word.vram_address            = res_ch.vram_address;
            seen_word.tile_fetch_address      = res_ch.tile_fetch_address;
            seen_word.attribute_fetch_address = res_ch.attribute_fetch_address;
            seen_word.attribute_shift         = res_ch.attribute_shift;
            seen_word.pattern_low_address     = res_ch.pattern_low_address;
            seen_word.fine_x_scroll           = res_ch.fine_x_scroll;
            seen_word.write_toggle            = res_ch.write_toggle;
            if (fetch_words_due.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                due_word = fetch_words_due.pop_front();
                compare_field("vram_address", seen_word.vram_address,
                              due_word.vram_address);
                compare_field("tile_fetch_address", seen_word.tile_fetch_address,
                              due_word.tile_fetch_address);
                compare_field("attribute_fetch_address", seen_word.attribute_fetch_address,
                              due_word.attribute_fetch_address);
                compare_field("attribute_shift", seen_word.attribute_shift,
                              due_word.attribute_shift);
                compare_field("pattern_low_address", seen_word.pattern_low_address,
                              due_word.pattern_low_address);
                compare_field("fine_x_scroll", seen_word.fine_x_scroll,
                              due_word.fine_x_scroll);
                compare_field("write_toggle", seen_word.write_toggle,
                              due_word.write_toggle);
            end
        end
    end

    // control bits both ways, then t loaded to all ones by a scroll pair
    task automatic test_control_and_scroll;
        send_word(ACT_CTRL_WR, 8'hFF, 1'b1, 8'hFF);
        send_word(ACT_CTRL_WR, 8'h03, 1'b1, 8'h00);
        send_word(ACT_SCROLL_WR, 8'hFF, 1'b1, 8'hA5);
        send_word(ACT_SCROLL_WR, 8'hFF, 1'b1, 8'h5A);
    endtask

    // v takes all of t through both copies
    task automatic test_copies;
        send_word(ACT_COPY_X, 8'h00, 1'b1, 8'hFF);
        send_word(ACT_COPY_Y, 8'h00, 1'b1, 8'h00);
    endtask

    // data step wrap, coarse x wrap, row 31 and last-row wraps
    task automatic test_increments;
        send_word(ACT_DATA, 8'h00, 1'b1, 8'h0F);
        send_word(ACT_COPY_X, 8'h00, 1'b1, 8'hF0);
        send_word(ACT_COPY_Y, 8'h00, 1'b1, 8'h00);
        send_word(ACT_INC_Y, 8'h00, 1'b1, 8'hFF);
        send_word(ACT_INC_X, 8'h00, 1'b1, 8'h00);
        send_word(ACT_SCROLL_WR, 8'h00, 1'b1, 8'h11);
        send_word(ACT_SCROLL_WR, 8'hEF, 1'b1, 8'h22);
        send_word(ACT_COPY_Y, 8'h00, 1'b1, 8'h33);
        send_word(ACT_INC_Y, 8'h00, 1'b1, 8'h44);
        send_word(ACT_INC_Y, 8'h00, 1'b1, 8'h55);
    endtask

    // address pair, status read between phases, 32 step
    task automatic test_address_writes;
        send_word(ACT_ADDR_WR, 8'hFF, 1'b1, 8'h00);
        send_word(ACT_STATUS_RD, 8'hFF, 1'b1, 8'hFF);
        send_word(ACT_ADDR_WR, 8'hFF, 1'b1, 8'h00);
        send_word(ACT_ADDR_WR, 8'hFF, 1'b1, 8'hFF);
        send_word(ACT_CTRL_WR, 8'h04, 1'b1, 8'h00);
        send_word(ACT_DATA, 8'h00, 1'b1, 8'hFF);
    endtask

    // writes ignored while disabled, status read still clears the toggle
    task automatic test_disabled_writes;
        send_word(ACT_CTRL_WR, 8'hFF, 1'b0, 8'h00);
        send_word(ACT_SCROLL_WR, 8'hFF, 1'b1, 8'hFF);
        send_word(ACT_ADDR_WR, 8'h00, 1'b0, 8'h00);
        send_word(ACT_STATUS_RD, 8'h00, 1'b0, 8'hFF);
        send_word(ACT_UNUSED_TOP, 8'hFF, 1'b1, 8'h00);
        send_word(ACT_UNUSED_LOW, 8'h00, 1'b0, 8'hFF);
        send_word(ACT_NONE, 8'hFF, 1'b1, 8'h00);
    endtask

    // mostly register sequences and render-like runs, some noise
    task automatic test_random(input int unsigned count);
        int unsigned stop_at;
        stop_at = action_count + count;
        while (action_count < stop_at) begin
            case ($urandom_range(9))
                0, 1: begin
                    send_word(ACT_STATUS_RD, any_byte(), mostly_enabled(), any_byte());
                    send_word(ACT_SCROLL_WR, any_byte(), mostly_enabled(), any_byte());
                    send_word(ACT_SCROLL_WR, any_byte(), mostly_enabled(), any_byte());
                end
                2: begin
                    send_word(ACT_STATUS_RD, any_byte(), mostly_enabled(), any_byte());
                    send_word(ACT_ADDR_WR, any_byte(), mostly_enabled(), any_byte());
                    send_word(ACT_ADDR_WR, any_byte(), mostly_enabled(), any_byte());
                    repeat ($urandom_range(1, 4))
                        send_word(ACT_DATA, any_byte(), mostly_enabled(), any_byte());
                end
                3, 4, 5: begin
                    repeat ($urandom_range(1, 8))
                        send_word(ACT_INC_X, any_byte(), mostly_enabled(), any_byte());
                    send_word(ACT_INC_Y, any_byte(), mostly_enabled(), any_byte());
                    send_word(ACT_COPY_X, any_byte(), mostly_enabled(), any_byte());
                end
                6: begin
                    send_word(ACT_COPY_Y, any_byte(), mostly_enabled(), any_byte());
                    repeat ($urandom_range(1, 10))
                        send_word(ACT_INC_Y, any_byte(), mostly_enabled(), any_byte());
                end
                7: send_word(ACT_CTRL_WR, any_byte(), mostly_enabled(), any_byte());
                default: begin
                    send_word(4'($urandom_range(15)), any_byte(), 1'($urandom_range(1)),
                              any_byte());
                end
            endcase
        end
    endtask

    initial begin
        cmd_ch.valid          <= 1'b0;
        cmd_ch.action         <= ACT_NONE;
        cmd_ch.data_byte      <= '0;
        cmd_ch.writes_enabled <= 1'b0;
        cmd_ch.tile_number    <= '0;
        i_rst_n               <= 1'b0;
        v_addr  = '0;
        t_addr  = '0;
        fine_x  = '0;
        toggle  = 1'b0;
        step_32 = 1'b0;
        bg_high = 1'b0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender idles little, receiver a lot
        send_idle_pct = 36;
        recv_idle_pct = 86;
        test_control_and_scroll();
        test_copies();
        test_increments();
        test_address_writes();
        test_disabled_writes();
        test_random(150);
        wait_results_drained();

        // sender idles a lot, receiver little
        send_idle_pct = 86;
        recv_idle_pct = 36;
        test_random(150);
        wait_results_drained();

        // full rate both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(150);

        cmd_ch.valid <= 1'b0;
        while (fetch_words_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
